### hw/rtl/b64d_pkg.sv
// shared types, constants and the alphabet lookup for the base64 decoder
`timescale 1ns / 1ps

package b64d_pkg;

  // result status carried on every result transaction
  typedef enum logic [1:0] {
    OUT_RUN  = 2'd0,
    OUT_DONE = 2'd1,
    OUT_BAD  = 2'd2
  } outcome_t;

  localparam logic [7:0]  PAD_CHAR  = 8'h3D;
  localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;
  localparam logic [6:0]  NOT_FOUND = 7'd64;

  // character to sextet; NOT_FOUND (bit 6 set) when outside the alphabet
  function automatic logic [6:0] sym_decode(input logic [7:0] ch);
    logic [6:0] idx;
    case (ch)
      8'h54: idx = 7'd0;   // T
      8'h52: idx = 7'd1;   // R
      8'h4F: idx = 7'd2;   // O
      8'h4E: idx = 7'd3;   // N
      8'h50: idx = 7'd4;   // P
      8'h4C: idx = 7'd5;   // L
      8'h41: idx = 7'd6;   // A
      8'h59: idx = 7'd7;   // Y
      8'h67: idx = 7'd8;   // g
      8'h42: idx = 7'd9;   // B
      8'h6A: idx = 7'd10;  // j
      8'h47: idx = 7'd11;  // G
      8'h56: idx = 7'd12;  // V
      8'h35: idx = 7'd13;  // 5
      8'h6C: idx = 7'd14;  // l
      8'h58: idx = 7'd15;  // X
      8'h55: idx = 7'd16;  // U
      8'h37: idx = 7'd17;  // 7
      8'h72: idx = 7'd18;  // r
      8'h39: idx = 7'd19;  // 9
      8'h74: idx = 7'd20;  // t
      8'h32: idx = 7'd21;  // 2
      8'h51: idx = 7'd22;  // Q
      8'h66: idx = 7'd23;  // f
      8'h6D: idx = 7'd24;  // m
      8'h4B: idx = 7'd25;  // K
      8'h6F: idx = 7'd26;  // o
      8'h43: idx = 7'd27;  // C
      8'h38: idx = 7'd28;  // 8
      8'h30: idx = 7'd29;  // 0
      8'h45: idx = 7'd30;  // E
      8'h46: idx = 7'd31;  // F
      8'h34: idx = 7'd32;  // 4
      8'h77: idx = 7'd33;  // w
      8'h71: idx = 7'd34;  // q
      8'h76: idx = 7'd35;  // v
      8'h64: idx = 7'd36;  // d
      8'h31: idx = 7'd37;  // 1
      8'h4D: idx = 7'd38;  // M
      8'h36: idx = 7'd39;  // 6
      8'h57: idx = 7'd40;  // W
      8'h48: idx = 7'd41;  // H
      8'h4A: idx = 7'd42;  // J
      8'h28: idx = 7'd43;  // (
      8'h70: idx = 7'd44;  // p
      8'h79: idx = 7'd45;  // y
      8'h78: idx = 7'd46;  // x
      8'h44: idx = 7'd47;  // D
      8'h5A: idx = 7'd48;  // Z
      8'h62: idx = 7'd49;  // b
      8'h29: idx = 7'd50;  // )
      8'h61: idx = 7'd51;  // a
      8'h69: idx = 7'd52;  // i
      8'h63: idx = 7'd53;  // c
      8'h6B: idx = 7'd54;  // k
      8'h33: idx = 7'd55;  // 3
      8'h73: idx = 7'd56;  // s
      8'h53: idx = 7'd57;  // S
      8'h6E: idx = 7'd58;  // n
      8'h49: idx = 7'd59;  // I
      8'h7A: idx = 7'd60;  // z
      8'h68: idx = 7'd61;  // h
      8'h65: idx = 7'd62;  // e
      8'h75: idx = 7'd63;  // u
      default: idx = NOT_FOUND;
    endcase
    return idx;
  endfunction

  // saturating add of a small byte count
  function automatic logic [23:0] sat_add(input logic [23:0] cnt, input logic [1:0] n);
    logic [24:0] s;
    s = {1'b0, cnt} + {23'd0, n};
    return s[24] ? COUNT_MAX : s[23:0];
  endfunction

endpackage

### hw/rtl/base64_custom_alphabet_decoder_unit.sv
// top level of the streaming base64 decoder over a permuted alphabet
`timescale 1ns / 1ps

// usage:
//   input channel: one text character per transaction (in_symbol), or an
//   end-of-text mark (in_end_of_text = 1) that closes the message; the next
//   transaction then starts a new message.
//   result channel: zero to three transactions per input transaction; each
//   carries a decoded byte or a bare status, the running byte count of the
//   message and out_last on the final result of that input transaction.
//   results of an input are registered and appear in the cycle after it is accepted.
//   throughput: one input per cycle while each input gives at most one
//   result and the result side does not stall; an input that completes a
//   group holds the input side until the last of its bytes (one to three)
//   leaves, since the result register sends at most one byte per cycle.
//   characters after the end of a message and an end-of-text mark after such
//   an end give no result and are taken whenever the input side is free.
//   reset clears the decoder state and empties the result register.
//   stall on the result side holds the current result; the input side takes
//   a new transaction as long as the result register is empty or its final
//   result leaves in the same cycle.
module base64_custom_alphabet_decoder_unit
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_symbol,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_has_data,
  output logic [1:0]  out_outcome,
  output logic [23:0] out_bytes_decoded,
  output logic        out_last
);

  // decoder state
  logic [1:0]  group_pos_r, group_pos_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic        third_pad_r, third_pad_nxt;
  logic        finished_r, finished_nxt;
  logic [23:0] byte_count_r, byte_count_nxt;

  // result register: a batch of up to three results
  logic [1:0]  rem_r, rem_nxt;
  logic [23:0] word_r, word_nxt;
  logic        has_r, has_nxt;
  outcome_t    outcome_r, outcome_nxt;
  logic [23:0] cnt_r, cnt_nxt;

  // per-item decode
  logic [6:0]  lk;
  logic        is_pad;
  logic        sym_ok;
  logic [5:0]  sx;
  logic        gen;
  logic        bad;
  logic [23:0] ld_word;
  logic [1:0]  ld_n;
  logic        ld_has;
  outcome_t    ld_outcome;

  logic in_acc;
  logic out_acc;

  assign out_valid = (rem_r != 2'd0);
  assign out_last  = (rem_r == 2'd1);
  assign out_acc   = out_valid && !out_stall;
  // free when empty or when the final result of the batch leaves now
  assign in_stall  = out_valid && !(out_last && !out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign out_data_byte     = word_r[23:16];
  assign out_has_data      = has_r;
  assign out_outcome       = outcome_r;
  assign out_bytes_decoded = cnt_r;

  assign lk     = sym_decode(in_symbol);
  assign is_pad = (in_symbol == PAD_CHAR);
  assign sym_ok = !is_pad && !lk[6];
  assign sx     = lk[5:0];

  // next decoder state and the batch this item produces
  always_comb begin
    group_pos_nxt  = group_pos_r;
    acc_nxt        = acc_r;
    third_pad_nxt  = third_pad_r;
    finished_nxt   = finished_r;
    byte_count_nxt = byte_count_r;
    gen            = 1'b0;
    bad            = 1'b0;
    ld_word        = 24'd0;
    ld_n           = 2'd1;
    ld_has         = 1'b0;
    ld_outcome     = OUT_RUN;
    if (in_end_of_text) begin
      if (!finished_r) begin
        gen        = 1'b1;
        ld_outcome = (group_pos_r == 2'd0) ? OUT_DONE : OUT_BAD;
      end
      group_pos_nxt  = 2'd0;
      acc_nxt        = 18'd0;
      third_pad_nxt  = 1'b0;
      finished_nxt   = 1'b0;
      byte_count_nxt = 24'd0;
    end else if (!finished_r) begin
      case (group_pos_r)
        2'd0: begin
          gen = 1'b1;
          if (!sym_ok) begin
            // quiet end of message
            finished_nxt = 1'b1;
            ld_outcome   = OUT_DONE;
          end else begin
            acc_nxt       = {12'd0, sx};
            group_pos_nxt = 2'd1;
          end
        end
        2'd1: begin
          if (!sym_ok) begin
            bad = 1'b1;
          end else begin
            gen           = 1'b1;
            acc_nxt       = {acc_r[11:0], sx};
            group_pos_nxt = 2'd2;
          end
        end
        2'd2: begin
          if (is_pad) begin
            gen           = 1'b1;
            third_pad_nxt = 1'b1;
            acc_nxt       = {acc_r[11:0], 6'd0};
            group_pos_nxt = 2'd3;
          end else if (!sym_ok) begin
            bad = 1'b1;
          end else begin
            gen           = 1'b1;
            acc_nxt       = {acc_r[11:0], sx};
            group_pos_nxt = 2'd3;
          end
        end
        default: begin
          if (is_pad) begin
            // padded group closes the message
            gen          = 1'b1;
            ld_word      = {acc_r, 6'd0};
            ld_n         = third_pad_r ? 2'd1 : 2'd2;
            ld_has       = 1'b1;
            ld_outcome   = OUT_DONE;
            finished_nxt = 1'b1;
          end else if (third_pad_r || !sym_ok) begin
            bad = 1'b1;
          end else begin
            gen        = 1'b1;
            ld_word    = {acc_r, sx};
            ld_n       = 2'd3;
            ld_has     = 1'b1;
            ld_outcome = OUT_RUN;
          end
          if (gen) begin
            group_pos_nxt  = 2'd0;
            acc_nxt        = 18'd0;
            third_pad_nxt  = 1'b0;
            byte_count_nxt = sat_add(byte_count_r, ld_n);
          end
        end
      endcase
      if (bad) begin
        gen          = 1'b1;
        finished_nxt = 1'b1;
        ld_outcome   = OUT_BAD;
      end
    end
  end

  // result register update: load a new batch or step through the current one
  always_comb begin
    rem_nxt     = rem_r;
    word_nxt    = word_r;
    has_nxt     = has_r;
    outcome_nxt = outcome_r;
    cnt_nxt     = cnt_r;
    if (in_acc && gen) begin
      rem_nxt     = ld_n;
      word_nxt    = ld_word;
      has_nxt     = ld_has;
      outcome_nxt = ld_outcome;
      cnt_nxt     = ld_has ? sat_add(byte_count_r, 2'd1) : byte_count_r;
    end else if (out_acc) begin
      rem_nxt = rem_r - 2'd1;
      if (!out_last) begin
        word_nxt = {word_r[15:0], 8'd0};
        cnt_nxt  = sat_add(cnt_r, 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_pos_r  <= 2'd0;
      acc_r        <= 18'd0;
      third_pad_r  <= 1'b0;
      finished_r   <= 1'b0;
      byte_count_r <= 24'd0;
      rem_r        <= 2'd0;
    end else begin
      if (in_acc) begin
        group_pos_r  <= group_pos_nxt;
        acc_r        <= acc_nxt;
        third_pad_r  <= third_pad_nxt;
        finished_r   <= finished_nxt;
        byte_count_r <= byte_count_nxt;
      end
      rem_r <= rem_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    has_r     <= has_nxt;
    outcome_r <= outcome_nxt;
    cnt_r     <= cnt_nxt;
  end

endmodule

### hw/rtl/b64d_checker.sv
// port-level checks for the base64 decoder, bound to the top level
`timescale 1ns / 1ps

module b64d_checker
  import b64d_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_data_byte,
  input logic        out_has_data,
  input logic [1:0]  out_outcome,
  input logic [23:0] out_bytes_decoded,
  input logic        out_last
);

  // a status-only result is always alone for its input
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_last && out_data_byte == 8'd0)
    else $error("status result not marked last or carries data");

  // a batch of bytes never breaks between its results
  a_batch_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && out_has_data)
    else $error("byte batch interrupted");

  // byte count climbs by one within a batch unless saturated
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      (out_bytes_decoded == $past(out_bytes_decoded) + 24'd1) ||
      (out_bytes_decoded == COUNT_MAX && $past(out_bytes_decoded) == COUNT_MAX))
    else $error("byte count did not step");

  // every result of a batch has the same status
  a_outcome_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_outcome == $past(out_outcome))
    else $error("status changed inside a batch");

endmodule

bind base64_custom_alphabet_decoder_unit b64d_checker u_b64d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_data_byte     (out_data_byte),
  .out_has_data      (out_has_data),
  .out_outcome       (out_outcome),
  .out_bytes_decoded (out_bytes_decoded),
  .out_last          (out_last)
);
